>>> hdl/assert_macros.svh
// Assertion macros for the vector magnitude limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define VML_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("label failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define VML_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");

`endif

>>> hdl/vml_pkg.sv
// Package: types, constants and per-stage step function of the magnitude limiter.
package vml_pkg;

  localparam int DataW     = 16;
  localparam int LenW      = 15;
  localparam int AddrW     = 3;
  localparam int SqrtSteps = 24;
  localparam int DivSteps  = 16;

  localparam int StSquare  = 1;
  localparam int StCompare = 2;
  localparam int StSqrtEnd = StCompare + SqrtSteps;
  localparam int StDivEnd  = StSqrtEnd + DivSteps;
  localparam int NumStages = StDivEnd + 2;

  localparam logic [LenW-1:0] MaxLenReset = '1;
  localparam logic [DataW-1:0] PosMax = {1'b0, {(DataW-1){1'b1}}};

  localparam logic [0:0] RegMaxLength = 1'b0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        m;
    logic               lim;
    logic [30:0]        sqx;
    logic [30:0]        sqy;
    logic [29:0]        mm;
    logic [47:0]        rad;
    logic [25:0]        rem;
    logic [23:0]        root;
    logic [23:0]        rx;
    logic [23:0]        ry;
    logic [15:0]        lx;
    logic [15:0]        ly;
    logic [15:0]        qx;
    logic [15:0]        qy;
  } vml_stage_t;

  function automatic logic [15:0] vml_abs(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [15:0] vml_fmt(input logic signed [15:0] c, input logic [15:0] q);
    logic [15:0] sat;
    sat = (q > PosMax) ? PosMax : q;
    return c[15] ? 16'(-sat) : sat;
  endfunction

  function automatic vml_stage_t vml_step(input int k, input vml_stage_t s);
    vml_stage_t  r;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [31:0] sum;
    logic [39:0] nx;
    logic [39:0] ny;
    logic [27:0] r2;
    logic [27:0] trial;
    logic [24:0] tx;
    logic [24:0] ty;
    r  = s;
    ax = vml_abs(s.x);
    ay = vml_abs(s.y);
    if (k == StSquare) begin
      r.sqx = 31'({16'b0, ax} * {16'b0, ax});
      r.sqy = 31'({16'b0, ay} * {16'b0, ay});
      r.mm  = 30'({15'b0, s.m} * {15'b0, s.m});
    end else if (k == StCompare) begin
      sum   = 32'(s.sqx) + 32'(s.sqy);
      r.lim = sum > {2'b0, s.mm};
      r.rad = {sum, 16'b0};
      r.rem = '0;
      r.root = '0;
      nx = {1'b0, 31'({15'b0, ax} * {16'b0, s.m}), 8'b0};
      ny = {1'b0, 31'({15'b0, ay} * {16'b0, s.m}), 8'b0};
      r.rx = nx[39:16];
      r.lx = nx[15:0];
      r.ry = ny[39:16];
      r.ly = ny[15:0];
      r.qx = '0;
      r.qy = '0;
    end else if (k <= StSqrtEnd) begin
      r2    = {s.rem, s.rad[47:46]};
      trial = {2'b0, s.root, 2'b01};
      r.rad = {s.rad[45:0], 2'b00};
      if (r2 >= trial) begin
        r.rem  = 26'(r2 - trial);
        r.root = {s.root[22:0], 1'b1};
      end else begin
        r.rem  = r2[25:0];
        r.root = {s.root[22:0], 1'b0};
      end
    end else if (k <= StDivEnd) begin
      tx   = {s.rx, s.lx[15]};
      ty   = {s.ry, s.ly[15]};
      r.lx = {s.lx[14:0], 1'b0};
      r.ly = {s.ly[14:0], 1'b0};
      if (tx >= {1'b0, s.root}) begin
        r.rx = 24'(tx - {1'b0, s.root});
        r.qx = {s.qx[14:0], 1'b1};
      end else begin
        r.rx = tx[23:0];
        r.qx = {s.qx[14:0], 1'b0};
      end
      if (ty >= {1'b0, s.root}) begin
        r.ry = 24'(ty - {1'b0, s.root});
        r.qy = {s.qy[14:0], 1'b1};
      end else begin
        r.ry = ty[23:0];
        r.qy = {s.qy[14:0], 1'b0};
      end
    end else begin
      if (s.lim) begin
        r.x = vml_fmt(s.x, s.qx);
        r.y = vml_fmt(s.y, s.qy);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/vml_pipe.sv
// Datapath pipeline: squares, compare, bit-per-stage square root and two dividers.
module vml_pipe import vml_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] in_x,
  input  logic signed [DataW-1:0] in_y,
  input  logic [LenW-1:0]         max_len,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] out_x,
  output logic signed [DataW-1:0] out_y,
  output logic                    out_lim
);

  vml_stage_t           stage [NumStages];
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;
  vml_stage_t           first;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_comb begin
    first   = '0;
    first.x = in_x;
    first.y = in_y;
    first.m = max_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
    if (en[0]) begin
      stage[0] <= first;
    end
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
      if (en[k]) begin
        stage[k] <= vml_step(k, stage[k-1]);
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NumStages-1];
  assign out_x     = stage[NumStages-1].x;
  assign out_y     = stage[NumStages-1].y;
  assign out_lim   = stage[NumStages-1].lim;

endmodule

>>> hdl/vector_magnitude_limit_core.sv
// Top level: circular vector magnitude limiter with APB register port.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | in_x, in_y
//  output   | out_valid / out_ready| out_x, out_y, was_limited
//  config   | APB psel/penable     | paddr, pwdata, prdata
//
// One transfer per cycle sustained while out_ready stays high, through a pipeline of
// squares, compare, 24 square-root stages (one root bit each) and 16 divide stages.
// Synchronous reset empties the pipeline and sets max_length to 32767.
// A stalled output holds; stages behind it keep filling bubbles.
`include "assert_macros.svh"
module vector_magnitude_limit_core import vml_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] in_x,
  input  logic signed [DataW-1:0] in_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] out_x,
  output logic signed [DataW-1:0] out_y,
  output logic                    was_limited
);

  logic [LenW-1:0] max_length;
  logic            wr_max;

  assign pready = 1'b1;
  assign wr_max = psel && penable && pwrite && (paddr[2] == RegMaxLength);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MaxLenReset;
    end else if (wr_max) begin
      max_length <= pwdata[LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxLength) begin
      prdata = {{(32-LenW){1'b0}}, max_length};
    end
  end

  vml_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .max_len   (max_length),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_lim   (was_limited)
  );

  `VML_ASSERT_NEXT(a_cfg_write, wr_max, max_length == $past(pwdata[LenW-1:0]))
  `VML_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)
  `VML_ASSERT_SAME(a_lim_no_negmax, out_valid && was_limited, out_x != {1'b1, {(DataW-1){1'b0}}})

endmodule

>>> tb/vector_magnitude_limit_core_tb.sv
// Testbench for the vector magnitude limiter: scoreboard prediction, random idling, APB config.
`timescale 1ns / 100ps
module vector_magnitude_limit_core_tb;
  import vml_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               lim;
  } vec_result_t;

  class limit_scoreboard;
    logic [14:0]  max_len;
    vec_result_t  pending[$];
    int           mismatches;

    function new();
      max_len = MaxLenReset;
      mismatches = 0;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function automatic logic [15:0] scale_comp(logic signed [15:0] c, logic [63:0] d);
      logic [63:0] mag;
      logic [63:0] q;
      mag = c < 0 ? 64'(-32'(c)) : 64'(c);
      q = (mag * max_len * 256) / d;
      if (q > 32767) q = 32767;
      return c < 0 ? 16'(-q) : 16'(q);
    endfunction

    function void note_vector(logic signed [15:0] x, logic signed [15:0] y);
      vec_result_t r;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] sq;
      logic [63:0] d;
      ax = x < 0 ? 64'(-32'(x)) : 64'(x);
      ay = y < 0 ? 64'(-32'(y)) : 64'(y);
      sq = ax * ax + ay * ay;
      if (sq > 64'(max_len) * max_len) begin
        d = root_floor(sq << 16);
        if (d == 0) d = 1;
        r.x = scale_comp(x, d);
        r.y = scale_comp(y, d);
        r.lim = 1;
      end else begin
        r.x = x;
        r.y = y;
        r.lim = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] x, logic signed [15:0] y, logic lim);
      vec_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d lim=%0b", x, y, lim);
        return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.lim !== lim) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d lim=%0b, got x=%0d y=%0d lim=%0b",
                   e.x, e.y, e.lim, x, y, lim);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic signed [DataW-1:0] in_x = '0, in_y = '0;
  logic out_valid, out_ready = 0;
  logic signed [DataW-1:0] out_x, out_y;
  logic was_limited;

  limit_scoreboard sb = new();
  int idle_cycles = 0;

  always #5 clk = ~clk;

  vector_magnitude_limit_core i_dut (.*);

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_vector(in_x, in_y);
    if (!rst && out_valid && out_ready) sb.check_result(out_x, out_y, was_limited);
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver idling
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic write_max(logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= AddrW'(RegMaxLength) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk iff pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.max_len = v[14:0];
  endtask

  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_x <= x; in_y <= y;
    @(posedge clk iff in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_vectors(int n);
    logic signed [15:0] x, y;
    int gap;
    repeat (n) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11);
      case ($urandom_range(0, 3))
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin
          x = 16'($urandom_range(0, 511) - 256);
          y = 16'($urandom_range(0, 511) - 256);
        end
        2: begin
          x = 16'($urandom_range(0, 8191) - 4096);
          y = 16'($urandom_range(0, 8191) - 4096);
        end
        default: begin
          x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
          y = 16'($urandom);
        end
      endcase
      send_vector(x, y, gap);
    end
  endtask

  initial begin
    logic [31:0] cfgs[6];
    cfgs = '{32'h0, 32'h7fff, 32'hffff_8100, 32'd1, 32'd256, 32'h0000_0a00};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_vector(16'sh7fff, 16'sh7fff, 0);
    send_vector(-16'sh8000, -16'sh8000, 0);
    send_vector(16'sh0, 16'sh0, 0);
    send_vector(16'sh7fff, 16'sh0, 0);
    send_vector(-16'sh8000, 16'sh0, 0);
    drain();
    write_max(32'd768);
    send_vector(16'sd768, 16'sd0, 0);
    send_vector(16'sd0, -16'sd768, 0);
    send_vector(16'sd769, 16'sd0, 0);
    send_vector(16'sd600, 16'sd600, 0);
    send_vector(-16'sh8000, -16'sh8000, 0);
    send_vector(-16'sh8000, 16'sd1, 0);
    drain();
    write_max(32'd0);
    send_vector(16'sd0, 16'sd0, 0);
    send_vector(16'sd1, 16'sd0, 0);
    send_vector(-16'sd5, 16'sd9, 0);
    drain();
    foreach (cfgs[i]) begin
      write_max(cfgs[i]);
      random_vectors(170);
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
